// ----- rtl/tlpm_pkg.sv -----
// ----------------------------------------------------------------------------
// tlpm_pkg: shared types and constants
// Page entry bit positions, fault codes and register indexes.
// ----------------------------------------------------------------------------
package tlpm_pkg;

  localparam int ENTRY_PRESENT_BIT  = 0;
  localparam int ENTRY_ACCESSED_BIT = 5;
  localparam int ENTRY_DIRTY_BIT    = 6;

  typedef enum logic [1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_DIR   = 2'd1,
    FAULT_TABLE = 2'd2,
    FAULT_RANGE = 2'd3
  } fault_t;

  localparam logic REG_PAGING_ENABLE = 1'b0;
  localparam logic REG_DIR_BASE      = 1'b1;

endpackage

// ----- rtl/two_level_paging_memory_access.sv -----
// ----------------------------------------------------------------------------
// two_level_paging_memory_access: byte memory with x86 two-level page walk
// One request of 1-4 bytes is translated (paging on) and performed on an
// internal byte memory through a single byte-wide port.
// ----------------------------------------------------------------------------
// A request is taken only when the block is idle and its result has been
// taken. All memory traffic goes one byte at a time through one RAM port:
// page entry reads, entry writebacks (skipped when the entry needs no
// update) and the data bytes. The memory has no reset; only bytes written
// may be read back.
module two_level_paging_memory_access #(
  parameter int MEM_BYTES = 262144
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [19:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [31:0] address,
  input  logic [2:0]  access_length,
  input  logic [31:0] write_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] read_data,
  output logic [1:0]  fault
);
  localparam int AW = $clog2(MEM_BYTES);

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_DRD, S_DRCHK, S_TRD, S_TRCHK, S_WBD, S_WBT,
    S_NEXT, S_DCHK, S_DATA, S_DWAIT, S_DONE
  } state_t;

  state_t      state;
  logic        paging_enable;
  logic [19:0] dir_frame;
  logic        wr;
  logic [31:0] va;       // request address
  logic [2:0]  len;
  logic [31:0] wdat;
  logic [2:0]  n0, n1;
  logic        second;   // walking the back page
  logic [31:0] pa0, pa1;
  logic [31:0] dir_addr, tab_addr, dir, tab;
  logic [1:0]  bcnt;     // byte counter for entry traffic
  logic [2:0]  dcnt;     // data byte counter
  logic        rpend;    // read issued last cycle
  logic [31:0] rd_acc;
  // shared RAM port
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata, ram_rdata;
  logic [31:0]   port_addr;

  function automatic logic fits(input logic [31:0] a, input logic [2:0] n);
    logic [33:0] s;
    s = {2'b0, a} + {31'b0, n};
    return s <= 34'(MEM_BYTES);
  endfunction

  function automatic logic [9:0] cur_va_next(input logic [31:0] a, input logic [2:0] n);
    logic [31:0] b;
    b = a + {29'b0, n};
    return b[31:22];
  endfunction

  logic [31:0] cur_va, data_pa, wb_val;
  logic [2:0]  data_n;
  assign cur_va  = second ? va + {29'b0, n0} : va;
  assign data_pa = (dcnt < n0) ? pa0 + {29'b0, dcnt} : pa1 + {29'b0, dcnt - n0};
  assign data_n  = n0 + n1;

  // walk writeback values
  logic dir_wb, tab_wb;
  logic [31:0] tab_new;
  assign dir_wb  = !dir[tlpm_pkg::ENTRY_ACCESSED_BIT];
  assign tab_wb  = !tab[tlpm_pkg::ENTRY_ACCESSED_BIT] ||
                   (wr && !tab[tlpm_pkg::ENTRY_DIRTY_BIT]);
  assign tab_new = tab | (32'(1) << tlpm_pkg::ENTRY_ACCESSED_BIT)
                 | (wr ? (32'(1) << tlpm_pkg::ENTRY_DIRTY_BIT) : 32'b0);
  assign wb_val  = (state == S_WBD) ? (dir | (32'(1) << tlpm_pkg::ENTRY_ACCESSED_BIT))
                                    : tab_new;

  always_comb begin
    ram_we    = 1'b0;
    port_addr = data_pa;
    ram_wdata = wdat[8*dcnt[1:0] +: 8];
    unique case (state)
      S_DRD: port_addr = dir_addr + {30'b0, bcnt};
      S_TRD: port_addr = tab_addr + {30'b0, bcnt};
      S_WBD: begin
        // no write when the table entry is absent or the directory is unchanged
        port_addr = dir_addr + {30'b0, bcnt};
        ram_we    = tab[tlpm_pkg::ENTRY_PRESENT_BIT] && dir_wb;
        ram_wdata = wb_val[8*bcnt +: 8];
      end
      S_WBT: begin
        port_addr = tab_addr + {30'b0, bcnt};
        ram_we    = tab_wb;
        ram_wdata = wb_val[8*bcnt +: 8];
      end
      S_DATA: ram_we = wr;
      default: ;
    endcase
  end
  assign ram_addr = port_addr[AW-1:0];

  tlpm_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  assign in_ready = (state == S_IDLE) && !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      paging_enable <= 1'b0;
      dir_frame     <= '0;
      out_valid     <= 1'b0;
      rpend         <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == tlpm_pkg::REG_PAGING_ENABLE) paging_enable <= cfg_data[0];
        else dir_frame <= cfg_data;
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            wr     <= operation;
            va     <= address;
            len    <= (access_length > 3'd4) ? 3'd4 : access_length;
            wdat   <= write_data;
            second <= 1'b0;
            pa0    <= address;
            rd_acc <= '0;
            state  <= S_START;
          end
        end
        S_START: begin
          if (len == 3'd0) begin
            n0    <= len;
            n1    <= '0;
            fault <= tlpm_pkg::FAULT_NONE;
            state <= S_DONE;
          end else if (paging_enable) begin
            if ({1'b0, va[11:0]} + {10'b0, len} > 13'd4096) begin
              n0 <= 3'(13'd4096 - {1'b0, va[11:0]});
              n1 <= 3'({1'b0, va[11:0]} + {10'b0, len} - 13'd4096);
            end else begin
              n0 <= len;
              n1 <= '0;
            end
            dir_addr <= {dir_frame, 12'b0} + {20'b0, va[31:22], 2'b0};
            state    <= S_DRCHK;
          end else begin
            n0    <= len;
            n1    <= '0;
            state <= S_DCHK;
          end
        end
        S_DRCHK: begin
          bcnt <= '0;
          if (!fits(dir_addr, 3'd4)) begin
            fault <= tlpm_pkg::FAULT_RANGE;
            state <= S_DONE;
          end else state <= S_DRD;
        end
        S_DRD, S_TRD: begin
          // issue 4 reads, collect each in the cycle after it is issued
          if (rpend) begin
            if (state == S_DRD) dir <= {ram_rdata, dir[31:8]};
            else                tab <= {ram_rdata, tab[31:8]};
          end
          if (rpend && bcnt == 2'd0) begin
            rpend <= 1'b0;
            bcnt  <= '0;
            state <= (state == S_DRD) ? S_TRCHK : S_WBD;
          end else begin
            rpend <= 1'b1;
            bcnt  <= bcnt + 2'd1;
          end
        end
        S_TRCHK: begin
          bcnt <= '0;
          if (!dir[tlpm_pkg::ENTRY_PRESENT_BIT]) begin
            fault <= tlpm_pkg::FAULT_DIR;
            state <= S_DONE;
          end else begin
            tab_addr <= {dir[31:12], 12'b0} + {20'b0, cur_va[21:12], 2'b0};
            state    <= S_NEXT; // reuse: range check next cycle
          end
        end
        S_NEXT: begin
          if (!fits(tab_addr, 3'd4)) begin
            fault <= tlpm_pkg::FAULT_RANGE;
            state <= S_DONE;
          end else state <= S_TRD;
        end
        S_WBD: begin
          if (bcnt == 2'd0 && !tab[tlpm_pkg::ENTRY_PRESENT_BIT]) begin
            fault <= tlpm_pkg::FAULT_TABLE;
            state <= S_DONE;
          end else if (!dir_wb) begin
            bcnt  <= '0;
            state <= S_WBT;
          end else begin
            bcnt <= bcnt + 2'd1;
            if (bcnt == 2'd3) begin
              dir   <= wb_val;
              state <= S_WBT;
            end
          end
        end
        S_WBT: begin
          if (!tab_wb || bcnt == 2'd3) begin
            bcnt <= '0;
            if (!second) pa0 <= {tab[31:12], va[11:0]};
            else         pa1 <= {tab[31:12], cur_va[11:0]};
            if (!second && n1 != 3'd0) begin
              second   <= 1'b1;
              dir_addr <= {dir_frame, 12'b0} +
                          {20'b0, cur_va_next(va, n0), 2'b0};
              state    <= S_DRCHK;
            end else state <= S_DCHK;
          end else bcnt <= bcnt + 2'd1;
        end
        S_DCHK: begin
          dcnt <= '0;
          if (!fits(pa0, n0) || (n1 != 3'd0 && !fits(pa1, n1))) begin
            fault <= tlpm_pkg::FAULT_RANGE;
            state <= S_DONE;
          end else begin
            fault <= tlpm_pkg::FAULT_NONE;
            state <= S_DATA;
          end
        end
        S_DATA: begin
          if (!wr) state <= S_DWAIT;
          else begin
            dcnt <= dcnt + 3'd1;
            if (dcnt + 3'd1 == data_n) state <= S_DONE;
          end
        end
        S_DWAIT: begin
          rd_acc[8*dcnt[1:0] +: 8] <= ram_rdata;
          dcnt  <= dcnt + 3'd1;
          state <= (dcnt + 3'd1 == data_n) ? S_DONE : S_DATA;
        end
        S_DONE: begin
          if (fault != tlpm_pkg::FAULT_NONE || wr) read_data <= 32'b0;
          else read_data <= rd_acc;
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- rtl/tlpm_ram.sv -----
// ----------------------------------------------------------------------------
// tlpm_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module tlpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 262144
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ----- rtl/tlpm_checker.sv -----
// ----------------------------------------------------------------------------
// tlpm_checker: port-level assertions
// Watches the request and result handshakes of the top level.
// ----------------------------------------------------------------------------
module tlpm_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] fault
);
  a_no_accept_while_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("request taken with result pending");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready) else $error("ready right after request");
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(fault)))
    else $error("result dropped");
endmodule

bind two_level_paging_memory_access tlpm_checker u_tlpm_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .fault(fault)
);

// ----- sim/two_level_paging_memory_access_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_level_paging_memory_access_tb: self-checking bench for the paging unit
// Sets up page directories and tables with physical writes, then sends
// directed and random requests with paging on and off. A class predicts
// each result and checks it. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module two_level_paging_memory_access_tb;

  localparam int MEM_BYTES = 262144;

  // what the block should answer for one request
  typedef struct {
    logic [31:0]      data;
    tlpm_pkg::fault_t flt;
  } access_result_t;

  // Shadow of the unit: byte memory, registers and the walk itself.
  // A dry run walks without writing and flags any read of a byte that
  // was never written, so the stimulus can avoid such reads.
  class paging_predictor;
    byte unsigned   mem[MEM_BYTES];
    bit             written[MEM_BYTES];
    bit             paging;
    bit [19:0]      dir_base;
    bit             dry;
    bit             unwritten_hit;
    access_result_t expected_q[$];
    int             mismatches;

    function bit fits(bit [31:0] pa, int n);
      return (64'(pa) + 64'(n)) <= 64'(MEM_BYTES);
    endfunction

    function bit [31:0] load(bit [31:0] pa, int n);
      bit [31:0] v;
      v = 0;
      for (int i = 0; i < n; i++) begin
        if (!written[pa + i]) unwritten_hit = 1;
        v |= 32'(mem[pa + i]) << (8 * i);
      end
      return v;
    endfunction

    function void store(bit [31:0] pa, int n, bit [31:0] v);
      if (dry) return;
      for (int i = 0; i < n; i++) begin
        mem[pa + i] = v[8*i +: 8];
        written[pa + i] = 1;
      end
    endfunction

    function tlpm_pkg::fault_t walk(bit [31:0] va, bit wr, output bit [31:0] pa);
      bit [31:0] dir_addr, dir, tab_addr, tab;
      pa = 0;
      dir_addr = {dir_base, 12'h0} + {20'h0, va[31:22], 2'b00};
      if (!fits(dir_addr, 4)) return tlpm_pkg::FAULT_RANGE;
      dir = load(dir_addr, 4);
      if (!dir[tlpm_pkg::ENTRY_PRESENT_BIT]) return tlpm_pkg::FAULT_DIR;
      tab_addr = {dir[31:12], 12'h0} + {20'h0, va[21:12], 2'b00};
      if (!fits(tab_addr, 4)) return tlpm_pkg::FAULT_RANGE;
      tab = load(tab_addr, 4);
      if (!tab[tlpm_pkg::ENTRY_PRESENT_BIT]) return tlpm_pkg::FAULT_TABLE;
      // accessed/dirty writebacks only when a bit actually changes
      if (!dir[tlpm_pkg::ENTRY_ACCESSED_BIT]) begin
        dir[tlpm_pkg::ENTRY_ACCESSED_BIT] = 1;
        store(dir_addr, 4, dir);
      end
      if (!tab[tlpm_pkg::ENTRY_ACCESSED_BIT] ||
          (wr && !tab[tlpm_pkg::ENTRY_DIRTY_BIT])) begin
        tab[tlpm_pkg::ENTRY_ACCESSED_BIT] = 1;
        if (wr) tab[tlpm_pkg::ENTRY_DIRTY_BIT] = 1;
        store(tab_addr, 4, tab);
      end
      pa = {tab[31:12], va[11:0]};
      return tlpm_pkg::FAULT_NONE;
    endfunction

    function access_result_t run(bit wr, bit [31:0] addr, bit [2:0] len, bit [31:0] wdata);
      access_result_t r;
      int n0, n1, n;
      bit [31:0] pa0, pa1;
      tlpm_pkg::fault_t f;
      r.data = 0;
      r.flt = tlpm_pkg::FAULT_NONE;
      if (len == 0) return r;
      n = (len > 4) ? 4 : len;
      n0 = n;
      n1 = 0;
      pa0 = addr;
      pa1 = 0;
      if (paging) begin
        // split when the access runs past the end of its 4 KiB page
        if (int'(addr[11:0]) + n > 4096) begin
          n0 = 4096 - int'(addr[11:0]);
          n1 = n - n0;
        end
        f = walk(addr, wr, pa0);
        if (f == tlpm_pkg::FAULT_NONE && n1 != 0) f = walk(addr + n0, wr, pa1);
        if (f != tlpm_pkg::FAULT_NONE) begin
          r.flt = f;
          return r;
        end
      end
      if (!fits(pa0, n0) || (n1 != 0 && !fits(pa1, n1))) begin
        r.flt = tlpm_pkg::FAULT_RANGE;
        return r;
      end
      if (wr) begin
        store(pa0, n0, wdata);
        if (n1 != 0) store(pa1, n1, wdata >> (8 * n0));
      end else begin
        r.data = load(pa0, n0);
        if (n1 != 0) r.data |= load(pa1, n1) << (8 * n0);
      end
      return r;
    endfunction

    function bit safe(bit wr, bit [31:0] addr, bit [2:0] len, bit [31:0] wdata);
      access_result_t r;
      dry = 1;
      unwritten_hit = 0;
      r = run(wr, addr, len, wdata);
      dry = 0;
      return !unwritten_hit;
    endfunction

    function void note_request(bit wr, bit [31:0] addr, bit [2:0] len, bit [31:0] wdata);
      expected_q.push_back(run(wr, addr, len, wdata));
    endfunction

    function void complain(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    function void check_result(logic [31:0] data, logic [1:0] flt);
      access_result_t e;
      if (expected_q.size() == 0) begin
        complain($sformatf("unexpected result data=%h fault=%0d", data, flt));
        return;
      end
      e = expected_q.pop_front();
      if (data !== e.data)
        complain($sformatf("read_data exp %h got %h", e.data, data));
      if (flt !== e.flt)
        complain($sformatf("fault exp %0d got %0d", e.flt, flt));
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic        cfg_index = tlpm_pkg::REG_PAGING_ENABLE;
  logic [19:0] cfg_data = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic        operation = 0;
  logic [31:0] address = 0;
  logic [2:0]  access_length = 0;
  logic [31:0] write_data = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [31:0] read_data;
  logic [1:0]  fault;

  paging_predictor pred = new();
  bit          idle_on = 1;
  int          hold_cycles = 0;   // receiver long stall, counted down below
  bit [31:0]   recent_writes[$];  // addresses read back later

  two_level_paging_memory_access #(.MEM_BYTES(MEM_BYTES)) dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // receiver: random stalls plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 0;
        hold_cycles--;
      end else if (idle_on && $urandom_range(0, 99) < 15) begin
        out_ready <= 0;
      end else begin
        out_ready <= 1;
      end
    end
  end

  always @(posedge clk)
    if (!rst && out_valid && out_ready) pred.check_result(read_data, fault);

  task automatic write_reg(logic idx, logic [19:0] value);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == tlpm_pkg::REG_PAGING_ENABLE) pred.paging = value[0];
    else pred.dir_base = value;
  endtask

  task automatic send_request(bit wr, bit [31:0] addr, bit [2:0] len, bit [31:0] wdata);
    if (idle_on && $urandom_range(0, 99) < 15) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1;
    operation <= wr;
    address <= addr;
    access_length <= len;
    write_data <= wdata;
    do @(posedge clk); while (!in_ready);
    pred.note_request(wr, addr, len, wdata);
    if (wr) begin
      recent_writes.push_back(addr);
      if (recent_writes.size() > 32) void'(recent_writes.pop_front());
    end
  endtask

  // sender stops until every result is back, then lets the block settle
  task automatic drain();
    in_valid <= 0;
    while (pred.expected_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic bit [31:0] pick_address(bit wr);
    bit [9:0] dir_idx, tab_idx;
    bit [11:0] off;
    int mode;
    if (!wr && recent_writes.size() > 0 && $urandom_range(0, 99) < 70)
      return recent_writes[$urandom_range(0, recent_writes.size() - 1)]
             + $urandom_range(0, 3);
    if (pred.paging) begin
      case ($urandom_range(0, 5))
        0: dir_idx = 0;
        1: dir_idx = 1;
        2: dir_idx = 2;
        3: dir_idx = 3;
        4: dir_idx = 10'h3ff;
        default: dir_idx = 10'($urandom);
      endcase
      case ($urandom_range(0, 5))
        0: tab_idx = 0;
        1: tab_idx = 1;
        2: tab_idx = 2;
        3: tab_idx = 3;
        4: tab_idx = 10'h3ff;
        default: tab_idx = 10'($urandom);
      endcase
      off = $urandom_range(0, 1) ? 12'($urandom) : 12'hff8 + 12'($urandom_range(0, 7));
      return {dir_idx, tab_idx, off};
    end
    // physical: data frames, the top edge of memory, or anywhere (faults)
    mode = $urandom_range(0, 99);
    if (mode < 60) return 32'h30000 + $urandom_range(0, 32'hffff);
    if (mode < 80) return 32'h3fff8 + $urandom_range(0, 7);
    return $urandom;
  endfunction

  task automatic random_requests(int count);
    bit wr;
    bit [31:0] addr, wdata;
    bit [2:0] len;
    int tries;
    repeat (count) begin
      tries = 0;
      do begin
        wr = $urandom_range(0, 1);
        len = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                          : 3'($urandom_range(1, 4));
        wdata = $urandom;
        addr = pick_address(wr);
        tries++;
      end while (!pred.safe(wr, addr, len, wdata) && tries < 64);
      // a zero-length request touches nothing, so it is always allowed
      if (!pred.safe(wr, addr, len, wdata)) len = 0;
      send_request(wr, addr, len, wdata);
    end
  endtask

  // page structures: directory A at frame 0x10, directory B at frame 0x20,
  // tables at frames 0x11 and 0x12, data frames from 0x30 up
  bit [31:0] setup_addr[16] = '{
    32'h10000, 32'h10004, 32'h10008, 32'h1000c, 32'h10ffc,
    32'h11000, 32'h11004, 32'h11008, 32'h1100c, 32'h11ffc,
    32'h12000, 32'h12004, 32'h12ffc,
    32'h20000, 32'h20004, 32'h20ffc};
  bit [31:0] setup_entry[16] = '{
    32'h00011001, 32'h00012021, 32'h00000000, 32'hfffff001, 32'h00011001,
    32'h00030001, 32'h00031001, 32'h00000000, 32'h00040001, 32'h00032001,
    32'h00033001, 32'h00034061, 32'h00035001,
    32'h00012001, 32'h00011001, 32'h00000000};

  initial begin
    repeat (2) @(posedge clk);
    rst <= 0;
    write_reg(tlpm_pkg::REG_PAGING_ENABLE, 0);
    write_reg(tlpm_pkg::REG_DIR_BASE, 0);

    // physical setup and directed checks with paging off
    for (int i = 0; i < 16; i++) send_request(1, setup_addr[i], 4, setup_entry[i]);
    send_request(0, 32'h11000, 4, 0);
    send_request(1, 32'h30000, 0, 32'hdeadbeef);        // empty access
    send_request(1, 32'h30000, 7, 32'ha5a55a5a);        // length above four
    send_request(0, 32'h30000, 1, 32'hffffffff);
    send_request(0, 32'h3fffe, 4, 0);                   // runs off the end
    send_request(1, 32'hffffffff, 1, 32'h12345678);
    drain();

    write_reg(tlpm_pkg::REG_PAGING_ENABLE, 1);
    write_reg(tlpm_pkg::REG_DIR_BASE, 20'h10);
    send_request(0, 32'h00800000, 4, 0);                // directory entry absent
    send_request(0, 32'h00002000, 4, 0);                // table entry absent
    send_request(0, 32'h00c00000, 4, 0);                // table beyond memory
    send_request(0, 32'h00003000, 4, 0);                // frame beyond memory
    send_request(1, 32'h00000010, 4, 32'h01020304);
    send_request(0, 32'h00000010, 4, 0);
    send_request(1, 32'h00001ffe, 4, 32'h55667788);     // split, back page absent
    send_request(1, 32'h003ffffd, 4, 32'hcafef00d);     // split across directories
    send_request(0, 32'h003ffffd, 4, 0);
    send_request(1, 32'hfffffffe, 4, 32'hbeadfeed);     // split wrapping to zero
    send_request(0, 32'hfffffffe, 4, 0);
    send_request(0, 32'h12345678, 0, 0);
    random_requests(130);

    // pressure: receiver holds off while the sender keeps offering
    hold_cycles = 400;
    random_requests(20);
    drain();

    write_reg(tlpm_pkg::REG_DIR_BASE, 20'h20);
    idle_on = 0;
    random_requests(70);
    idle_on = 1;
    drain();

    write_reg(tlpm_pkg::REG_DIR_BASE, 20'hfffff);       // every walk out of range
    random_requests(10);
    drain();

    write_reg(tlpm_pkg::REG_PAGING_ENABLE, 0);
    random_requests(100);
    drain();

    write_reg(tlpm_pkg::REG_PAGING_ENABLE, 1);
    write_reg(tlpm_pkg::REG_DIR_BASE, 20'h10);
    random_requests(50);
    drain();

    if (pred.mismatches == 0 && pred.expected_q.size() == 0) begin
      $display("two_level_paging_memory_access_tb OK");
    end else begin
      $display("two_level_paging_memory_access_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("two_level_paging_memory_access_tb NOT OK");
    $finish;
  end

endmodule
